[rtl/hsb_pkg.sv]
package hsb_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int ADDR_W    = $clog2(MAX_ITEMS);
  localparam int CNT_W     = ADDR_W + 1;

  typedef logic [7:0]        byte_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_BUILD_INIT,
    ST_BUILD_CHECK,
    ST_SORT_CHECK,
    ST_SORT_RD,
    ST_SORT_WR0,
    ST_SORT_WRK,
    ST_SIFT_START,
    ST_SIFT_CUR,
    ST_SIFT_NEXT,
    ST_SIFT_LEFT,
    ST_SIFT_RIGHT,
    ST_SIFT_SWAP,
    ST_SIFT_W2,
    ST_OUT_LOAD,
    ST_OUT_WAIT
  } state_t;

  typedef enum logic [2:0] {
    RD_CUR,
    RD_LEFT,
    RD_RIGHT,
    RD_ZERO,
    RD_KM1,
    RD_KP1
  } rd_sel_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_CUR_BEST,
    WR_BEST_CUR,
    WR_ZERO_RDATA,
    WR_KM1_CUR
  } wr_sel_t;

  typedef enum logic [2:0] {
    K_HOLD,
    K_HALF_N,
    K_N,
    K_DEC,
    K_INC,
    K_ZERO
  } k_op_t;

  typedef enum logic [1:0] {
    CUR_HOLD,
    CUR_KM1,
    CUR_ZERO,
    CUR_BEST
  } cur_op_t;

  typedef enum logic [1:0] {
    HS_HOLD,
    HS_N,
    HS_KM1
  } hs_op_t;

  typedef struct packed {
    logic    load;
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
    k_op_t   k_op;
    cur_op_t cur_op;
    hs_op_t  hs_op;
    logic    cur_capture;
    logic    best_from_cur;
    logic    cmp_left;
    logic    cmp_right;
    logic    hold_capture;
    logic    out_load;
    logic    msg_clear;
  } cmd_t;

  typedef struct packed {
    logic in_last;
    logic left_out;
    logic k_zero;
    logic k_le1;
    logic best_is_cur;
    logic out_end;
  } sts_t;

endpackage

[rtl/hsb_if.sv]
interface hsb_in_if;
  logic          valid;
  logic          ready;
  hsb_pkg::byte_t byte_value;
  logic          is_last;

  modport source (output valid, output byte_value, output is_last, input ready);
  modport sink   (input valid, input byte_value, input is_last, output ready);
endinterface

interface hsb_out_if;
  logic          valid;
  logic          ready;
  hsb_pkg::byte_t sorted_value;
  logic          end_of_run;
  logic          truncated;

  modport source (output valid, output sorted_value, output end_of_run, output truncated,
                  input ready);
  modport sink   (input valid, input sorted_value, input end_of_run, input truncated,
                  output ready);
endinterface

[rtl/hsb_dpath.sv]
module hsb_dpath (
  input  logic           clk,
  input  logic           rst_n,
  input  hsb_pkg::cmd_t  cmd,
  output hsb_pkg::sts_t  sts,
  input  hsb_pkg::byte_t in_byte,
  input  logic           in_last,
  output hsb_pkg::byte_t out_value,
  output logic           out_end,
  output logic           out_trunc
);

  hsb_pkg::byte_t mem [hsb_pkg::MAX_ITEMS];
  hsb_pkg::byte_t rdata_r;

  hsb_pkg::cnt_t  count_r, count_nxt;
  logic           ovf_r, ovf_nxt;
  hsb_pkg::cnt_t  k_r, k_nxt;
  hsb_pkg::cnt_t  hs_r, hs_nxt;
  hsb_pkg::addr_t cur_r, cur_nxt;
  hsb_pkg::addr_t bi_r, bi_nxt;
  hsb_pkg::byte_t cv_r, cv_nxt;
  hsb_pkg::byte_t bv_r, bv_nxt;
  hsb_pkg::byte_t out_value_r, out_value_nxt;
  logic           out_end_r, out_end_nxt;

  hsb_pkg::cnt_t         left_w;
  logic [hsb_pkg::CNT_W:0] right_w;
  logic                  right_in;
  hsb_pkg::cnt_t         km1_w;
  hsb_pkg::cnt_t         kp1_w;
  logic                  room_w;
  hsb_pkg::addr_t        raddr;
  logic                  we;
  hsb_pkg::addr_t        waddr;
  hsb_pkg::byte_t        wdata;

  assign left_w   = {cur_r, 1'b1};
  assign right_w  = {1'b0, left_w} + {{hsb_pkg::CNT_W{1'b0}}, 1'b1};
  assign right_in = right_w < {1'b0, hs_r};
  assign km1_w    = k_r - hsb_pkg::cnt_t'(1);
  assign kp1_w    = k_r + hsb_pkg::cnt_t'(1);
  assign room_w   = count_r < hsb_pkg::cnt_t'(hsb_pkg::MAX_ITEMS);

  assign sts.in_last     = in_last;
  assign sts.left_out    = left_w >= hs_r;
  assign sts.k_zero      = k_r == '0;
  assign sts.k_le1       = k_r <= hsb_pkg::cnt_t'(1);
  assign sts.best_is_cur = bi_r == cur_r;
  assign sts.out_end     = out_end_r;

  assign out_value = out_value_r;
  assign out_end   = out_end_r;
  assign out_trunc = ovf_r;

  always_comb begin
    unique case (cmd.rd_sel)
      hsb_pkg::RD_CUR:   raddr = cur_r;
      hsb_pkg::RD_LEFT:  raddr = left_w[hsb_pkg::ADDR_W-1:0];
      hsb_pkg::RD_RIGHT: raddr = right_w[hsb_pkg::ADDR_W-1:0];
      hsb_pkg::RD_ZERO:  raddr = '0;
      hsb_pkg::RD_KM1:   raddr = km1_w[hsb_pkg::ADDR_W-1:0];
      hsb_pkg::RD_KP1:   raddr = kp1_w[hsb_pkg::ADDR_W-1:0];
      default:           raddr = cur_r;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = cur_r;
    wdata = bv_r;
    if (cmd.load) begin
      we    = room_w;
      waddr = count_r[hsb_pkg::ADDR_W-1:0];
      wdata = in_byte;
    end else begin
      unique case (cmd.wr_sel)
        hsb_pkg::WR_NONE: we = 1'b0;
        hsb_pkg::WR_CUR_BEST: begin
          we    = 1'b1;
          waddr = cur_r;
          wdata = bv_r;
        end
        hsb_pkg::WR_BEST_CUR: begin
          we    = 1'b1;
          waddr = bi_r;
          wdata = cv_r;
        end
        hsb_pkg::WR_ZERO_RDATA: begin
          we    = 1'b1;
          waddr = '0;
          wdata = rdata_r;
        end
        hsb_pkg::WR_KM1_CUR: begin
          we    = 1'b1;
          waddr = km1_w[hsb_pkg::ADDR_W-1:0];
          wdata = cv_r;
        end
        default: we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    if (cmd.msg_clear) begin
      count_nxt = '0;
      ovf_nxt   = 1'b0;
    end else if (cmd.load) begin
      if (room_w) begin
        count_nxt = count_r + hsb_pkg::cnt_t'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    unique case (cmd.k_op)
      hsb_pkg::K_HOLD:   k_nxt = k_r;
      hsb_pkg::K_HALF_N: k_nxt = count_r >> 1;
      hsb_pkg::K_N:      k_nxt = count_r;
      hsb_pkg::K_DEC:    k_nxt = km1_w;
      hsb_pkg::K_INC:    k_nxt = kp1_w;
      hsb_pkg::K_ZERO:   k_nxt = '0;
      default:           k_nxt = k_r;
    endcase
    unique case (cmd.cur_op)
      hsb_pkg::CUR_HOLD: cur_nxt = cur_r;
      hsb_pkg::CUR_KM1:  cur_nxt = km1_w[hsb_pkg::ADDR_W-1:0];
      hsb_pkg::CUR_ZERO: cur_nxt = '0;
      hsb_pkg::CUR_BEST: cur_nxt = bi_r;
      default:           cur_nxt = cur_r;
    endcase
    unique case (cmd.hs_op)
      hsb_pkg::HS_HOLD: hs_nxt = hs_r;
      hsb_pkg::HS_N:    hs_nxt = count_r;
      hsb_pkg::HS_KM1:  hs_nxt = km1_w;
      default:          hs_nxt = hs_r;
    endcase
  end

  always_comb begin
    cv_nxt = cv_r;
    bv_nxt = bv_r;
    bi_nxt = bi_r;
    if (cmd.cur_capture) begin
      cv_nxt = rdata_r;
      bv_nxt = rdata_r;
      bi_nxt = cur_r;
    end else if (cmd.best_from_cur) begin
      bv_nxt = cv_r;
      bi_nxt = cur_r;
    end else if (cmd.cmp_left) begin
      if (rdata_r > bv_r) begin
        bv_nxt = rdata_r;
        bi_nxt = left_w[hsb_pkg::ADDR_W-1:0];
      end
    end else if (cmd.cmp_right) begin
      if (right_in && (rdata_r > bv_r)) begin
        bv_nxt = rdata_r;
        bi_nxt = right_w[hsb_pkg::ADDR_W-1:0];
      end
    end else if (cmd.hold_capture) begin
      cv_nxt = rdata_r;
    end
  end

  always_comb begin
    out_value_nxt = out_value_r;
    out_end_nxt   = out_end_r;
    if (cmd.out_load) begin
      out_value_nxt = rdata_r;
      out_end_nxt   = kp1_w == count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r         <= k_nxt;
    hs_r        <= hs_nxt;
    cur_r       <= cur_nxt;
    bi_r        <= bi_nxt;
    cv_r        <= cv_nxt;
    bv_r        <= bv_nxt;
    out_value_r <= out_value_nxt;
    out_end_r   <= out_end_nxt;
  end

endmodule

[rtl/hsb_ctrl.sv]
module hsb_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  hsb_pkg::sts_t sts,
  output hsb_pkg::cmd_t cmd
);

  hsb_pkg::state_t state_r, state_nxt;
  logic            sort_phase_r, sort_phase_nxt;
  hsb_pkg::state_t sift_ret;

  assign sift_ret = sort_phase_r ? hsb_pkg::ST_SORT_CHECK : hsb_pkg::ST_BUILD_CHECK;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= hsb_pkg::ST_LOAD;
      sort_phase_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      sort_phase_r <= sort_phase_nxt;
    end
  end

  always_comb begin
    state_nxt          = state_r;
    sort_phase_nxt     = sort_phase_r;
    in_ready           = 1'b0;
    out_valid          = 1'b0;
    cmd.load           = 1'b0;
    cmd.rd_sel         = hsb_pkg::RD_CUR;
    cmd.wr_sel         = hsb_pkg::WR_NONE;
    cmd.k_op           = hsb_pkg::K_HOLD;
    cmd.cur_op         = hsb_pkg::CUR_HOLD;
    cmd.hs_op          = hsb_pkg::HS_HOLD;
    cmd.cur_capture    = 1'b0;
    cmd.best_from_cur  = 1'b0;
    cmd.cmp_left       = 1'b0;
    cmd.cmp_right      = 1'b0;
    cmd.hold_capture   = 1'b0;
    cmd.out_load       = 1'b0;
    cmd.msg_clear      = 1'b0;

    unique case (state_r)
      hsb_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        if (in_valid && sts.in_last) begin
          sort_phase_nxt = 1'b0;
          state_nxt      = hsb_pkg::ST_BUILD_INIT;
        end
      end
      hsb_pkg::ST_BUILD_INIT: begin
        cmd.k_op  = hsb_pkg::K_HALF_N;
        state_nxt = hsb_pkg::ST_BUILD_CHECK;
      end
      hsb_pkg::ST_BUILD_CHECK: begin
        if (sts.k_zero) begin
          cmd.k_op       = hsb_pkg::K_N;
          sort_phase_nxt = 1'b1;
          state_nxt      = hsb_pkg::ST_SORT_CHECK;
        end else begin
          cmd.cur_op = hsb_pkg::CUR_KM1;
          cmd.hs_op  = hsb_pkg::HS_N;
          state_nxt  = hsb_pkg::ST_SIFT_START;
        end
      end
      hsb_pkg::ST_SORT_CHECK: begin
        cmd.rd_sel = hsb_pkg::RD_ZERO;
        if (sts.k_le1) begin
          cmd.k_op  = hsb_pkg::K_ZERO;
          state_nxt = hsb_pkg::ST_OUT_LOAD;
        end else begin
          state_nxt = hsb_pkg::ST_SORT_RD;
        end
      end
      hsb_pkg::ST_SORT_RD: begin
        cmd.hold_capture = 1'b1;
        cmd.rd_sel       = hsb_pkg::RD_KM1;
        state_nxt        = hsb_pkg::ST_SORT_WR0;
      end
      hsb_pkg::ST_SORT_WR0: begin
        cmd.wr_sel = hsb_pkg::WR_ZERO_RDATA;
        state_nxt  = hsb_pkg::ST_SORT_WRK;
      end
      hsb_pkg::ST_SORT_WRK: begin
        cmd.wr_sel = hsb_pkg::WR_KM1_CUR;
        cmd.cur_op = hsb_pkg::CUR_ZERO;
        cmd.hs_op  = hsb_pkg::HS_KM1;
        state_nxt  = hsb_pkg::ST_SIFT_START;
      end
      hsb_pkg::ST_SIFT_START: begin
        if (sts.left_out) begin
          cmd.k_op  = hsb_pkg::K_DEC;
          state_nxt = sift_ret;
        end else begin
          cmd.rd_sel = hsb_pkg::RD_CUR;
          state_nxt  = hsb_pkg::ST_SIFT_CUR;
        end
      end
      hsb_pkg::ST_SIFT_CUR: begin
        cmd.cur_capture = 1'b1;
        cmd.rd_sel      = hsb_pkg::RD_LEFT;
        state_nxt       = hsb_pkg::ST_SIFT_LEFT;
      end
      hsb_pkg::ST_SIFT_NEXT: begin
        if (sts.left_out) begin
          cmd.k_op  = hsb_pkg::K_DEC;
          state_nxt = sift_ret;
        end else begin
          cmd.best_from_cur = 1'b1;
          cmd.rd_sel        = hsb_pkg::RD_LEFT;
          state_nxt         = hsb_pkg::ST_SIFT_LEFT;
        end
      end
      hsb_pkg::ST_SIFT_LEFT: begin
        cmd.cmp_left = 1'b1;
        cmd.rd_sel   = hsb_pkg::RD_RIGHT;
        state_nxt    = hsb_pkg::ST_SIFT_RIGHT;
      end
      hsb_pkg::ST_SIFT_RIGHT: begin
        cmd.cmp_right = 1'b1;
        state_nxt     = hsb_pkg::ST_SIFT_SWAP;
      end
      hsb_pkg::ST_SIFT_SWAP: begin
        if (sts.best_is_cur) begin
          cmd.k_op  = hsb_pkg::K_DEC;
          state_nxt = sift_ret;
        end else begin
          cmd.wr_sel = hsb_pkg::WR_CUR_BEST;
          state_nxt  = hsb_pkg::ST_SIFT_W2;
        end
      end
      hsb_pkg::ST_SIFT_W2: begin
        cmd.wr_sel = hsb_pkg::WR_BEST_CUR;
        cmd.cur_op = hsb_pkg::CUR_BEST;
        state_nxt  = hsb_pkg::ST_SIFT_NEXT;
      end
      hsb_pkg::ST_OUT_LOAD: begin
        cmd.out_load = 1'b1;
        state_nxt    = hsb_pkg::ST_OUT_WAIT;
      end
      hsb_pkg::ST_OUT_WAIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.out_end) begin
            cmd.msg_clear = 1'b1;
            state_nxt     = hsb_pkg::ST_LOAD;
          end else begin
            cmd.k_op   = hsb_pkg::K_INC;
            cmd.rd_sel = hsb_pkg::RD_KP1;
            state_nxt  = hsb_pkg::ST_OUT_LOAD;
          end
        end
      end
      default: state_nxt = hsb_pkg::ST_LOAD;
    endcase
  end

endmodule

[rtl/heap_sort_bytes.sv]
// Byte heapsort: collect a message, sort it ascending, stream it back.
// Input channel in_ch: one byte per item; the item with is_last set closes
//   the message. in_ch.ready is high only while a message is being loaded,
//   one item per cycle. Bytes beyond 64 are dropped and flagged.
// Output channel out_ch: one sorted byte per item, end_of_run on the final
//   one, truncated on every item of a message that lost bytes.
// Sorting: after the closing item, a heap build and sort-down pass run on
//   the buffer memory, which has one read port and one write port. Each
//   sift level reads cur (first level only), left and right, then takes two
//   writes for a swap; each extraction adds a root swap with the last item.
// Throughput: one byte loaded per cycle; each emitted byte is read as the
//   previous one is taken, loaded in ST_OUT_LOAD and offered in ST_OUT_WAIT.
// Stall: a result holds on out_ch until taken; sorting work is complete by
//   then, so only the emission sequence waits.
// Reset (rst_n, synchronous): byte count and drop flag clear, the block
//   waits for the first byte of a message. No memory clearing is needed.
module heap_sort_bytes (
  input  logic  clk,
  input  logic  rst_n,
  hsb_in_if.sink    in_ch,
  hsb_out_if.source out_ch
);

  hsb_pkg::cmd_t cmd;
  hsb_pkg::sts_t sts;

  hsb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  hsb_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_byte   (in_ch.byte_value),
    .in_last   (in_ch.is_last),
    .out_value (out_ch.sorted_value),
    .out_end   (out_ch.end_of_run),
    .out_trunc (out_ch.truncated)
  );

endmodule
